// ===== rtl/exp_taylor_horner_assert.svh =====
// assertion helpers for the exp taylor pipeline
`ifndef EXP_TAYLOR_HORNER_ASSERT_SVH
`define EXP_TAYLOR_HORNER_ASSERT_SVH

// same-cycle implication
`define ETH_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ETH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/eth_pkg.sv =====
`timescale 1ns / 1ps

package eth_pkg;

  localparam int MAX_TERMS = 20;
  localparam int KW        = $clog2(MAX_TERMS + 1);
  localparam int TW        = 5;   // term_count register width
  localparam int XW        = 19;  // argument, Q3.16
  localparam int XKW       = 28;  // x/k, Q.24
  localparam int SW        = 32;  // running sum, Q8.24
  localparam int OW        = 22;  // result, Q6.16
  localparam int RIW       = 6;   // reciprocal table index
  localparam int RW        = 25;  // reciprocal, Q1.24 (k = 1 needs bit 24)
  localparam logic [TW-1:0] TERM_COUNT_RESET = TW'(20);

  typedef struct packed {
    logic signed [XW-1:0]  x;
    logic signed [XKW-1:0] xk;
    logic signed [SW-1:0]  sum;
    logic [KW-1:0]         n;
  } stage_t;

  // round(2^24 / k)
  function automatic logic [RW-1:0] recip_q24(input logic [RIW-1:0] k);
    logic [RW-1:0] r;
    unique case (k)
      6'd1:  r = 25'd16777216;
      6'd2:  r = 25'd8388608;
      6'd3:  r = 25'd5592405;
      6'd4:  r = 25'd4194304;
      6'd5:  r = 25'd3355443;
      6'd6:  r = 25'd2796203;
      6'd7:  r = 25'd2396745;
      6'd8:  r = 25'd2097152;
      6'd9:  r = 25'd1864135;
      6'd10: r = 25'd1677722;
      6'd11: r = 25'd1525201;
      6'd12: r = 25'd1398101;
      6'd13: r = 25'd1290555;
      6'd14: r = 25'd1198373;
      6'd15: r = 25'd1118481;
      6'd16: r = 25'd1048576;
      6'd17: r = 25'd986895;
      6'd18: r = 25'd932068;
      6'd19: r = 25'd883011;
      6'd20: r = 25'd838861;
      6'd21: r = 25'd798915;
      6'd22: r = 25'd762601;
      6'd23: r = 25'd729444;
      6'd24: r = 25'd699051;
      6'd25: r = 25'd671089;
      6'd26: r = 25'd645278;
      6'd27: r = 25'd621378;
      6'd28: r = 25'd599186;
      6'd29: r = 25'd578525;
      6'd30: r = 25'd559241;
      6'd31: r = 25'd541201;
      6'd32: r = 25'd524288;
      default: r = '0;
    endcase
    return r;
  endfunction

  // x * (1/k), rounded half up to Q.24
  function automatic logic signed [XKW-1:0] x_over_k(input logic signed [XW-1:0] x,
                                                     input logic [RIW-1:0] k);
    logic signed [RW:0]     r;
    logic signed [XW+RW:0]  p;
    r = signed'({1'b0, recip_q24(k)});
    p = x * r;
    p = p + (XW+RW+1)'(32768);
    return p[XKW+15:16];
  endfunction

endpackage

// ===== rtl/eth_front.sv =====
`timescale 1ns / 1ps

module eth_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic signed [eth_pkg::XW-1:0] in_x,
  input  logic [eth_pkg::TW-1:0]        term_count,
  output logic                          out_valid,
  output eth_pkg::stage_t               out_data
);
  import eth_pkg::*;

  logic [KW-1:0] n_sat;
  stage_t        data_next;

  always_comb begin
    if ((TW+1)'(term_count) > (TW+1)'(MAX_TERMS)) begin
      n_sat = KW'(MAX_TERMS);
    end else begin
      n_sat = KW'(term_count);
    end
    data_next.x   = in_x;
    data_next.xk  = x_over_k(in_x, RIW'(MAX_TERMS));
    data_next.sum = '0;
    data_next.n   = n_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/eth_cell.sv =====
`timescale 1ns / 1ps

module eth_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [eth_pkg::KW-1:0] step_k,
  input  logic                   in_valid,
  input  eth_pkg::stage_t        in_data,
  output logic                   out_valid,
  output eth_pkg::stage_t        out_data
);
  import eth_pkg::*;

  logic signed [XKW+SW-1:0]  prod_full;
  logic signed [XKW+SW-25:0] prod;     // product in Q.24, 36 bits
  logic signed [XKW+SW-24:0] sum_wide;
  logic signed [SW-1:0]      sum_sat;
  logic [KW-1:0]             k_next;
  stage_t                    data_next;

  always_comb begin
    // one horner step: sum = 1 + (x/k) * sum
    prod_full = in_data.xk * in_data.sum;
    prod_full = prod_full + (XKW+SW)'(8388608);
    prod      = prod_full[XKW+SW-1:24];
    sum_wide  = {prod[XKW+SW-25], prod} + (XKW+SW-23)'(16777216);
    if (sum_wide > (XKW+SW-23)'(64'sh7FFF_FFFF)) begin
      sum_sat = {1'b0, {(SW-1){1'b1}}};
    end else if (sum_wide < -(XKW+SW-23)'(64'sh8000_0000)) begin
      sum_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sum_sat = sum_wide[SW-1:0];
    end

    // x/k for the neighbor, one index lower
    k_next         = step_k - KW'(1);
    data_next.x    = in_data.x;
    data_next.xk   = x_over_k(in_data.x, RIW'(k_next));
    data_next.n    = in_data.n;
    // steps above the term count leave the sum alone
    data_next.sum  = (in_data.n >= step_k) ? sum_sat : in_data.sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== rtl/eth_out.sv =====
`timescale 1ns / 1ps

module eth_out (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic signed [eth_pkg::SW-1:0] in_sum,
  output logic                          out_valid,
  output logic [eth_pkg::OW-1:0]        out_value
);
  import eth_pkg::*;

  logic signed [SW:0]   rnd;
  logic signed [SW-8:0] scaled;
  logic [OW-1:0]        value_next;

  always_comb begin
    // Q8.24 -> Q6.16, round half up, clamp
    rnd    = {in_sum[SW-1], in_sum} + (SW+1)'(128);
    scaled = rnd[SW:8];
    if (scaled < 0) begin
      value_next = '0;
    end else if (scaled > (SW-7)'((1 << OW) - 1)) begin
      value_next = '1;
    end else begin
      value_next = scaled[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value <= value_next;
    end
  end

endmodule

// ===== rtl/exp_taylor_horner.sv =====
// exp_taylor_horner: e^x by a horner-form maclaurin series, one cell per term
// stages: input stage + one cell per k + output stage
// throughput: one word per cycle; the whole chain holds while the output word waits
// reset: synchronous, active high; empties every stage, term_count back to 20
// no clearing pass, s_tready is high in the first cycle with reset low
`timescale 1ns / 1ps
`include "exp_taylor_horner_assert.svh"

module exp_taylor_horner (
  input  logic        clk,
  input  logic        rst,
  // config: term_count
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  // argument words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [18:0] arg_x, signed q3.16
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [21:0] exp_value, unsigned q6.16
);
  import eth_pkg::*;

  // term count register; write only while the chain is empty (user's duty, not enforced here)
  logic [TW-1:0] term_count;

  // whole chain moves together; the output register takes a word when it is
  // empty or being drained
  logic advance;

  // chain links: index 0 leaves the input stage, MAX_TERMS leaves the last cell
  logic   chain_valid [MAX_TERMS+1];
  stage_t chain_data  [MAX_TERMS+1];

  logic [OW-1:0] exp_value;

  assign advance  = !m_tvalid || m_tready;
  // no argument is taken while reset is held
  assign s_tready = !rst && advance;
  assign m_tdata  = {{(24-OW){1'b0}}, exp_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= TERM_COUNT_RESET;
    end else if (cfg_wr_en) begin
      term_count <= cfg_wr_data;
    end
  end

  // input stage: latch x, saturate term count, precompute x/MAX_TERMS
  eth_front u_front (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .in_valid   (s_tvalid),
    .in_x       (signed'(s_tdata[XW-1:0])),
    .term_count (term_count),
    .out_valid  (chain_valid[0]),
    .out_data   (chain_data[0])
  );

  // cell i applies the step for k = MAX_TERMS - i, highest k first
  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    eth_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .step_k    (KW'(MAX_TERMS - i)),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // rounding, clamping and the output register
  eth_out u_out (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (chain_valid[MAX_TERMS]),
    .in_sum    (chain_data[MAX_TERMS].sum),
    .out_valid (m_tvalid),
    .out_value (exp_value)
  );

  // an accepted argument lands in the input stage
  `ETH_ASSERT_NEXT(a_accept_lands, clk, rst, s_tvalid && s_tready, chain_valid[0])

  // a word leaving the last cell shows up at the output
  `ETH_ASSERT_NEXT(a_last_to_out, clk, rst, chain_valid[MAX_TERMS] && advance, m_tvalid)

  // while the output is stalled the chain freezes
  `ETH_ASSERT_NEXT(a_stall_holds, clk, rst, !advance,
                   $stable(chain_valid[MAX_TERMS]) && $stable(chain_valid[0]))

endmodule

// ===== bench/exp_taylor_horner_tb.sv =====
`timescale 1ns / 1ps

module exp_taylor_horner_tb;
  import eth_pkg::*;

  // expected e^x values, in order of acceptance
  class exp_scoreboard;
    logic [TW-1:0] terms;
    logic [OW-1:0] exp_pending[$];
    int errors;

    function new();
      terms = TERM_COUNT_RESET;
      errors = 0;
    endfunction

    // horner evaluation of the truncated series, sum in q8.24
    function logic [OW-1:0] horner_exp(logic signed [XW-1:0] x);
      longint sum, xk, prod, rk, res;
      int n;
      n = (terms > MAX_TERMS) ? MAX_TERMS : int'(terms);
      sum = 0;
      for (int k = n; k > 0; k--) begin
        rk = ((longint'(1) << 24) + k / 2) / k;
        xk = (longint'(x) * rk + (longint'(1) << 15)) >>> 16;
        prod = (xk * sum + (longint'(1) << 23)) >>> 24;
        sum = (longint'(1) << 24) + prod;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      end
      res = (sum + 128) >>> 8;
      if (res < 0) res = 0;
      if (res > 4194303) res = 4194303;
      return res[OW-1:0];
    endfunction

    function void note_arg(logic signed [XW-1:0] x);
      exp_pending.push_back(horner_exp(x));
    endfunction

    function void check_result(logic [OW-1:0] got);
      logic [OW-1:0] want;
      if (exp_pending.size() == 0) begin
        $display("%0t: unexpected result word, got %0d", $time, got);
        errors++;
        return;
      end
      want = exp_pending.pop_front();
      if (got !== want) begin
        $display("%0t: exp_value mismatch, expected %0d, got %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [18:0] arg_x
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // [21:0] exp_value

  exp_scoreboard sb = new();
  bit  calm;                   // no gaps on either side while set
  int  stall_left;
  longint cycles;

  localparam longint CYCLE_LIMIT = 400000;

  exp_taylor_horner dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: check accepted words, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata[OW-1:0]);
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      m_tready <= 1'b1;
    end
  end

  task automatic send_arg(logic signed [XW-1:0] x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, x};
    do @(posedge clk); while (!s_tready);
    sb.note_arg(x);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.exp_pending.size() != 0) @(posedge clk);
  endtask

  // only while idle: every word sent has come back
  task automatic set_terms(logic [TW-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.terms = v;
  endtask

  // uniform over the field, with shares near -4, near 0 and just under 4
  function automatic logic [XW-1:0] rand_arg();
    case ($urandom_range(0, 9))
      0: return XW'(-262144 + $urandom_range(0, 255));
      1: return XW'(262143 - $urandom_range(0, 255));
      2: return XW'($urandom_range(0, 511) - 256);
      default: return XW'($urandom_range(0, (1 << XW) - 1));
    endcase
  endfunction

  logic signed [XW-1:0] corner_args[10] = '{
    -19'sd262144, 19'sd262143, 19'sd0, -19'sd1, 19'sd1,
    19'sd65536, -19'sd65536, 19'sh2AAAA, -19'sd174763, 19'sd131072
  };
  logic [TW-1:0] rand_terms[8] = '{5'd20, 5'd0, 5'd1, 5'd31, 5'd0, 5'd0, 5'd21, 5'd0};

  initial begin
    int phase;
    calm = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner arguments at the reset term count
    foreach (corner_args[i]) send_arg(corner_args[i]);
    // zero terms gives zero, above the table saturates to the full count
    set_terms(5'd0);
    send_arg(19'sd262143);
    send_arg(-19'sd262144);
    set_terms(5'd1);
    send_arg(19'sd262143);
    send_arg(-19'sd1);
    set_terms(5'd31);
    send_arg(19'sd262143);
    send_arg(-19'sd262144);
    set_terms(5'd21);
    send_arg(19'sd100000);
    set_terms(5'd2);
    send_arg(-19'sd262144);
    send_arg(19'sd262143);

    // random phases; 0 in the table means a random term count, but in phase 1 it is used as is
    for (phase = 0; phase < 8; phase++) begin
      set_terms(rand_terms[phase] == 0 && phase != 1 ? TW'($urandom_range(0, 31))
                                                    : rand_terms[phase]);
      calm = (phase % 3 == 2);
      repeat (75) send_arg(rand_arg());
    end
    calm = 0;

    drain();
    repeat (MAX_TERMS + 10) @(posedge clk);
    if (sb.errors == 0 && sb.exp_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
